/* hw/rtl/lir_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lir_pkg
// shared constants and controller/datapath interface types of the resampler
// ----------------------------------------------------------------------------
package lir_pkg;

  // fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int CHIDX_W    = 3;
  localparam int NCH_W      = 4;
  localparam int POS_W      = 32;
  localparam int FRAC_BITS  = 12;
  localparam int POS_ONE    = 4096;
  localparam int MIN_STEP   = 1024;

  // configuration port
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam logic REG_STEP     = 1'b0;
  localparam logic REG_CHANNELS = 1'b1;
  localparam logic [POS_W-1:0] STEP_RESET     = 32'd4096;
  localparam logic [NCH_W-1:0] CHANNELS_RESET = 4'd2;

  // defaults of the top level parameters
  localparam int DEF_MAX_CHANNELS     = 8;
  localparam int DEF_FRAME_INDEX_BITS = 20;

  // controller to datapath
  typedef struct packed {
    logic load;    // take one input sample into the frame being assembled
    logic emit;    // produce one output sample and step the channel
    logic skip;    // position already beyond the frame: drop one frame
    logic tail;    // interpolate the last frame against itself
    logic commit;  // frame complete: move it to the previous frame
    logic clear;   // end of block: position and counters to zero
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_done;  // the sample now offered completes a frame
    logic fc_nz;       // at least one frame completed in this block
    logic eob;         // latched end of block of the current input
    logic rp_ge_one;   // position at or beyond the next frame
    logic chan_last;   // output channel is the last of the frame
    logic sum_ge_one;  // next position leaves the frame interval
    logic out_free;    // output register can take a new result
  } status_t;

endpackage
`default_nettype wire

/* hw/rtl/lir_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lir_cfg
// register port holding step and channel count, with their effective values
// ----------------------------------------------------------------------------
module lir_cfg #(
  parameter int MAX_CHANNELS = lir_pkg::DEF_MAX_CHANNELS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lir_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [lir_pkg::PDATA_W-1:0]  pwdata,
  output logic      [lir_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output logic      [lir_pkg::POS_W-1:0]    step_eff,
  output logic      [lir_pkg::NCH_W-1:0]    nch_eff
);
  import lir_pkg::*;

  logic [POS_W-1:0] step;
  logic [NCH_W-1:0] channel_count;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= STEP_RESET;
      channel_count <= CHANNELS_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_STEP:     step          <= pwdata;
        REG_CHANNELS: channel_count <= pwdata[NCH_W-1:0];
        default:      step          <= step;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_CHANNELS) ?
                  {{(PDATA_W-NCH_W){1'b0}}, channel_count} : step;

  // small steps raise to the 4x limit
  assign step_eff = (step < POS_W'(MIN_STEP)) ? POS_W'(MIN_STEP) : step;

  always_comb begin
    if (channel_count == '0) begin
      nch_eff = NCH_W'(1);
    end else if (channel_count > NCH_W'(MAX_CHANNELS)) begin
      nch_eff = NCH_W'(MAX_CHANNELS);
    end else begin
      nch_eff = channel_count;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/lir_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lir_ctrl
// sequencer: takes a sample, runs the interpolation phases, ends the block
// ----------------------------------------------------------------------------
module lir_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire lir_pkg::status_t status,
  output lir_pkg::cmd_t         cmd
);
  import lir_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MAIN   = 3'd1;
  localparam logic [2:0] ST_COMMIT = 3'd2;
  localparam logic [2:0] ST_ENDCHK = 3'd3;
  localparam logic [2:0] ST_TAIL   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       phase_end;

  always_comb begin
    state_next = state;
    cmd        = '0;
    phase_end  = 1'b0;
    s_tready   = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (status.frame_done) begin
            state_next = status.fc_nz ? ST_MAIN : ST_COMMIT;
          end else begin
            state_next = ST_ENDCHK;
          end
        end
      end
      ST_MAIN, ST_TAIL: begin
        cmd.tail = (state == ST_TAIL);
        if (status.rp_ge_one) begin
          cmd.skip  = 1'b1;
          phase_end = 1'b1;
        end else if (status.out_free) begin
          cmd.emit  = 1'b1;
          phase_end = status.chan_last & status.sum_ge_one;
        end
        if (phase_end) begin
          if (state == ST_TAIL) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_COMMIT;
          end
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_ENDCHK;
      end
      ST_ENDCHK: begin
        if (status.eob && status.fc_nz) begin
          state_next = ST_TAIL;
        end else begin
          cmd.clear  = status.eob;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("result produced while output register full");

  a_commit_src: assert property (@(posedge clk) disable iff (rst)
    state == ST_COMMIT |-> $past(state) == ST_MAIN || $past(state) == ST_IDLE)
    else $error("frame commit reached from wrong state");

endmodule
`default_nettype wire

/* hw/rtl/lir_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lir_dpath
// frame stores, read position, interpolator and output register
// ----------------------------------------------------------------------------
module lir_dpath #(
  parameter int MAX_CHANNELS     = lir_pkg::DEF_MAX_CHANNELS,
  parameter int FRAME_INDEX_BITS = lir_pkg::DEF_FRAME_INDEX_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire lir_pkg::cmd_t                       cmd,
  output lir_pkg::status_t                         status,
  input  wire logic        [lir_pkg::POS_W-1:0]    step_eff,
  input  wire logic        [lir_pkg::NCH_W-1:0]    nch_eff,
  input  wire logic signed [lir_pkg::SAMPLE_W-1:0] sample_in,
  input  wire logic                                end_of_block,
  input  wire logic                                m_tready,
  output logic                                     m_tvalid,
  output logic signed      [lir_pkg::SAMPLE_W-1:0] sample_out,
  output logic             [lir_pkg::CHIDX_W-1:0]  channel_index,
  output logic                                     run_last,
  output logic                                     block_done
);
  import lir_pkg::*;

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // (a*(4096-f) + b*f) / 4096 as a + (b-a)*f, truncated toward zero
  function automatic logic signed [SAMPLE_W-1:0] lerp(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic        [FRAC_BITS-1:0] f
  );
    logic signed [SAMPLE_W:0]             diff;
    logic signed [SAMPLE_W+FRAC_BITS+1:0] prod;
    logic signed [SAMPLE_W+FRAC_BITS+2:0] acc;
    logic signed [SAMPLE_W+2:0]           q;
    diff = $signed({b[SAMPLE_W-1], b}) - $signed({a[SAMPLE_W-1], a});
    prod = diff * $signed({1'b0, f});
    acc  = $signed({{3{a[SAMPLE_W-1]}}, a, {FRAC_BITS{1'b0}}})
         + $signed({prod[SAMPLE_W+FRAC_BITS+1], prod});
    q    = acc[SAMPLE_W+FRAC_BITS+2:FRAC_BITS];
    if (acc[SAMPLE_W+FRAC_BITS+2] && (acc[FRAC_BITS-1:0] != '0)) begin
      q = q + $signed({{(SAMPLE_W+2){1'b0}}, 1'b1});
    end
    return q[SAMPLE_W-1:0];
  endfunction

  logic signed [SAMPLE_W-1:0]     previous_frame [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0]     current_frame  [MAX_CHANNELS];
  logic        [POS_W-1:0]        read_position;
  logic        [FRAME_INDEX_BITS-1:0] frame_counter;
  logic        [CH_W-1:0]         channel_counter;
  logic        [CH_W-1:0]         out_chan;
  logic                           eob;

  logic        [POS_W:0]          pos_sum;
  logic        [POS_W-1:0]        pos_wrapped;
  logic                           tail_empty;
  logic                           is_last;
  logic signed [SAMPLE_W-1:0]     lo_smp;
  logic signed [SAMPLE_W-1:0]     hi_smp;

  assign pos_sum     = {1'b0, read_position} + {1'b0, step_eff};
  assign pos_wrapped = POS_W'(pos_sum - (POS_W+1)'(POS_ONE));
  // a following tail phase has nothing to emit once the sum reaches two frames
  assign tail_empty  = |pos_sum[POS_W:FRAC_BITS+1];

  assign lo_smp  = previous_frame[out_chan];
  assign hi_smp  = cmd.tail ? previous_frame[out_chan] : current_frame[out_chan];

  always_comb begin
    status.frame_done = (NCH_W'(channel_counter) + NCH_W'(1)) >= nch_eff;
    status.chan_last  = (NCH_W'(out_chan) + NCH_W'(1)) >= nch_eff;
    status.fc_nz      = |frame_counter;
    status.eob        = eob;
    status.rp_ge_one  = |read_position[POS_W-1:FRAC_BITS];
    status.sum_ge_one = |pos_sum[POS_W:FRAC_BITS];
    status.out_free   = ~m_tvalid | m_tready;
  end

  assign is_last = status.chan_last & status.sum_ge_one & (cmd.tail | ~eob | tail_empty);

  // frame stores
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      current_frame[channel_counter] <= sample_in;
      eob                            <= end_of_block;
    end
    if (cmd.commit) begin
      previous_frame <= current_frame;
    end
  end

  // position and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      read_position   <= '0;
      frame_counter   <= '0;
      channel_counter <= '0;
      out_chan        <= '0;
    end else begin
      if (cmd.emit) begin
        out_chan <= status.chan_last ? '0 : out_chan + 1'b1;
      end
      if (cmd.clear) begin
        read_position   <= '0;
        frame_counter   <= '0;
        channel_counter <= '0;
      end else begin
        if (cmd.load) begin
          channel_counter <= status.frame_done ? '0 : channel_counter + 1'b1;
        end
        if (cmd.skip) begin
          read_position <= read_position - POS_W'(POS_ONE);
        end else if (cmd.emit && status.chan_last) begin
          read_position <= status.sum_ge_one ? pos_wrapped : pos_sum[POS_W-1:0];
        end
        if (cmd.commit && (frame_counter != '1)) begin
          frame_counter <= frame_counter + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sample_out    <= lerp(lo_smp, hi_smp, read_position[FRAC_BITS-1:0]);
      channel_index <= CHIDX_W'(out_chan);
      run_last      <= is_last;
      block_done    <= is_last & eob;
    end
  end

  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && !(status.chan_last && status.sum_ge_one) |=> !status.rp_ge_one)
    else $error("position left frame interval while phase continues");

  a_skip_at_entry: assert property (@(posedge clk) disable iff (rst)
    cmd.skip |-> out_chan == '0)
    else $error("frame skip in the middle of an output frame");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && block_done |-> run_last)
    else $error("block end flagged on a result that is not last");

endmodule
`default_nettype wire

/* hw/rtl/linear_interp_resampler.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_interp_resampler
// linear interpolation sample rate converter for interleaved 16-bit audio
// ----------------------------------------------------------------------------
// Interleaved signed samples enter one per transfer, channel 0 first; each
// completed frame is paired with the one before it and output frames are
// produced at a 20.12 read position advancing by the step register, each
// sample (a*(4096-f)+b*f)/4096 truncated toward zero. Outputs between two
// frames leave as soon as the later frame completes, and those that remain
// on the last frame (paired with itself) leave with the end-of-block sample.
// An input transfer is accepted, then the output samples it releases follow
// (up to 4 frames of channel_count samples between two frames and up to 4
// more on the tail at a block end, so 64 at most), with a skip step when the
// position already lies past the frame in either phase, then frame commit and
// end check; a stalled output holds the sequence. The serial interpolator
// produces one output sample per cycle while the output register is free.
// The output register decouples the two sides: a new sample is taken while
// the last result of the previous one still waits.
// ----------------------------------------------------------------------------
module linear_interp_resampler #(
  parameter int MAX_CHANNELS     = lir_pkg::DEF_MAX_CHANNELS,
  parameter int FRAME_INDEX_BITS = lir_pkg::DEF_FRAME_INDEX_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration: step at 0x0, channel_count at 0x4
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lir_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [lir_pkg::PDATA_W-1:0]  pwdata,
  output logic      [lir_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  // input samples
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [15:0]                  s_tdata,   // [15:0] sample_in
  input  wire logic                         s_tlast,   // end_of_block
  // output samples
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic      [23:0]                  m_tdata,   // [15:0] sample_out,
                                                       // [18:16] channel_index
  output logic                              m_tlast,   // run_last
  output logic      [0:0]                   m_tuser    // [0] block_done
);
  import lir_pkg::*;

  cmd_t                         cmd;
  status_t                      status;
  logic        [POS_W-1:0]      step_eff;
  logic        [NCH_W-1:0]      nch_eff;
  logic signed [SAMPLE_W-1:0]   sample_out;
  logic        [CHIDX_W-1:0]    channel_index;
  logic                         block_done;

  // register port, clamps step and channel count to their usable range
  lir_cfg #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .step_eff (step_eff),
    .nch_eff  (nch_eff)
  );

  // sequencer: accept, main phase, frame commit, end-of-block tail
  lir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // frames, position, interpolator and output register
  lir_dpath #(
    .MAX_CHANNELS     (MAX_CHANNELS),
    .FRAME_INDEX_BITS (FRAME_INDEX_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .step_eff      (step_eff),
    .nch_eff       (nch_eff),
    .sample_in     ($signed(s_tdata)),
    .end_of_block  (s_tlast),
    .m_tready      (m_tready),
    .m_tvalid      (m_tvalid),
    .sample_out    (sample_out),
    .channel_index (channel_index),
    .run_last      (m_tlast),
    .block_done    (block_done)
  );

  // pack the result, zero fill to whole bytes
  assign m_tdata = {5'b0, channel_index, sample_out};
  assign m_tuser = block_done;

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the linear interpolation resampler
// ----------------------------------------------------------------------------
// Interleaved samples go in as stream transfers and every output transfer is
// checked against a local model of the resampler. The model keeps its own
// read position, frame counters and frame stores. A short directed run
// covers the field extremes, the largest burst of outputs, clamped step and
// channel settings, an empty block, a block with no tail and channel count
// changes in the middle of a frame. Random blocks then follow under three
// idle patterns, with one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import lir_pkg::*;

  localparam int MAX_CH         = DEF_MAX_CHANNELS;
  localparam int FRAME_MAX      = (1 << DEF_FRAME_INDEX_BITS) - 1;
  localparam int SETTLE_CYCLES  = 100;   // worst-case work of one input with no output
  localparam int HOLD_CYCLES    = 300;   // long output hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
  localparam int ITEMS_PER_MODE = 90;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [CHIDX_W-1:0]         channel_index;
    logic                       run_last;
    logic                       block_done;
  } resampled_t;

  // model of the converter plus the queue of outputs still to arrive
  class resampler_scoreboard;
    logic [POS_W-1:0]           step_val;
    logic [NCH_W-1:0]           chan_val;
    logic [POS_W-1:0]           read_pos;
    int unsigned                frames_done;
    logic [CHIDX_W-1:0]         next_chan;
    logic signed [SAMPLE_W-1:0] prev_frame [MAX_CH];
    logic signed [SAMPLE_W-1:0] cur_frame [MAX_CH];
    resampled_t                 expected_q [$];
    int                         errors;

    function new();
      step_val    = STEP_RESET;
      chan_val    = CHANNELS_RESET;
      read_pos    = '0;
      frames_done = 0;
      next_chan   = '0;
      errors      = 0;
      foreach (prev_frame[i]) begin
        prev_frame[i] = '0;
        cur_frame[i]  = '0;
      end
    endfunction

    function void write_reg(logic idx, logic [PDATA_W-1:0] value);
      if (idx == REG_STEP) begin
        step_val = value;
      end else begin
        chan_val = value[NCH_W-1:0];
      end
    endfunction

    // zero reads as one, anything above the store size as the store size
    function int unsigned channels();
      if (chan_val == 0) return 1;
      if (chan_val > MAX_CH) return MAX_CH;
      return chan_val;
    endfunction

    function logic signed [SAMPLE_W-1:0] lerp(int a, int b, int frac);
      int acc;
      acc = a * (POS_ONE - frac) + b * frac;
      return SAMPLE_W'(acc / POS_ONE);
    endfunction

    // output frames that fall between the previous and the current frame,
    // or on the previous frame alone for the tail of a block
    function void emit_frames(bit with_self, int unsigned nch);
      logic [POS_W:0] pos;
      logic [POS_W:0] inc;
      resampled_t     r;
      inc = (step_val < MIN_STEP) ? (POS_W + 1)'(MIN_STEP) : {1'b0, step_val};
      pos = {1'b0, read_pos};
      while (pos < POS_ONE) begin
        for (int c = 0; c < nch; c++) begin
          r.sample_out    = lerp(prev_frame[c], with_self ? prev_frame[c] : cur_frame[c],
                                 int'(pos[FRAC_BITS-1:0]));
          r.channel_index = CHIDX_W'(c);
          r.run_last      = 1'b0;
          r.block_done    = 1'b0;
          expected_q.push_back(r);
        end
        pos = pos + inc;
      end
      read_pos = POS_W'(pos - POS_ONE);
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] value, logic eob);
      int unsigned nch;
      int          queued_at_start;
      resampled_t  r;
      nch             = channels();
      queued_at_start = expected_q.size();
      cur_frame[next_chan] = value;
      if (int'(next_chan) + 1 >= nch) begin
        next_chan = '0;
        if (frames_done != 0) emit_frames(1'b0, nch);
        prev_frame = cur_frame;
        if (frames_done < FRAME_MAX) frames_done++;
      end else begin
        next_chan = next_chan + 1'b1;
      end
      if (eob) begin
        if (frames_done != 0) emit_frames(1'b1, nch);
        read_pos    = '0;
        frames_done = 0;
        next_chan   = '0;
      end
      if (expected_q.size() > queued_at_start) begin
        r            = expected_q.pop_back();
        r.run_last   = 1'b1;
        r.block_done = eob;
        expected_q.push_back(r);
      end
    endfunction

    function void check_output(resampled_t got);
      resampled_t want;
      if (expected_q.size() == 0) begin
        $error("output with nothing expected: sample_out %0d channel_index %0d",
               got.sample_out, got.channel_index);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.sample_out !== want.sample_out) begin
        $error("sample_out: expected %0d, got %0d", want.sample_out, got.sample_out);
        errors++;
      end
      if (got.channel_index !== want.channel_index) begin
        $error("channel_index: expected %0d, got %0d", want.channel_index,
               got.channel_index);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
        errors++;
      end
      if (got.block_done !== want.block_done) begin
        $error("block_done: expected %0b, got %0b", want.block_done, got.block_done);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                s_tvalid;
  logic                s_tready;
  logic [15:0]         s_tdata;   // [15:0] sample_in
  logic                s_tlast;   // end_of_block
  logic                m_tvalid;
  logic                m_tready;
  logic [23:0]         m_tdata;   // [15:0] sample_out, [18:16] channel_index
  logic                m_tlast;   // run_last
  logic [0:0]          m_tuser;   // [0] block_done

  resampler_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit stall_req     = 0;
  int quiet_cycles  = 0;

  linear_interp_resampler dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // transfer monitor: inputs feed the model first so a result taken at the
  // same edge is still matched against the older expectations
  always @(posedge clk) begin
    resampled_t seen;
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_sample(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        seen.sample_out    = m_tdata[15:0];
        seen.channel_index = m_tdata[18:16];
        seen.run_last      = m_tlast;
        seen.block_done    = m_tuser[0];
        sb.check_output(seen);
      end
      if (psel && penable && pwrite && pready) sb.write_reg(paddr[2], pwdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // watchdog on a block that has stopped moving
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("linear_interp_resampler: mismatch");
    $finish;
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // setup and access phases, then the bus returns to idle
  task automatic apb_write(input logic idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // one input transfer, then an optional idle gap
  task automatic send_sample(input logic [15:0] value, input logic eob);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= eob;
    do @(posedge clk); while (!s_tready);
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 5);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // all outputs in, then room for work that produces no output
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic pick_settings(output logic [POS_W-1:0] st, output logic [NCH_W-1:0] cc);
    case ($urandom_range(7))
      0:       st = MIN_STEP;
      1:       st = $urandom_range(MIN_STEP - 1, 0);
      2:       st = POS_ONE;
      3:       st = 32'hFFFF_FFFF;
      4:       st = $urandom;
      default: st = $urandom_range(MIN_STEP, 4 * POS_ONE);
    endcase
    if ($urandom_range(9) == 0) begin
      cc = NCH_W'($urandom_range(15));
    end else begin
      cc = NCH_W'($urandom_range(1, MAX_CH));
    end
  endtask

  // mostly whole frames ending on end of block; some blocks end inside a
  // frame and some end before their first frame completes
  task automatic send_block(input int nch, output int count);
    int   kind;
    logic [15:0] value;
    kind  = $urandom_range(9);
    count = $urandom_range(1, (24 / nch > 1) ? 24 / nch : 1) * nch;
    if (kind == 0) begin
      count = $urandom_range(1, nch);
    end else if (kind == 1 && nch > 1) begin
      count = count + $urandom_range(1, nch - 1);
    end
    for (int i = 0; i < count; i++) begin
      value = 16'($urandom);
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0:       value = 16'h8000;
          1:       value = 16'h7FFF;
          2:       value = 16'h0000;
          default: value = 16'hFFFF;
        endcase
      end
      send_sample(value, i == count - 1);
    end
  endtask

  initial begin
    logic [15:0]      edge_frames [16];
    logic [POS_W-1:0] st;
    logic [NCH_W-1:0] cc;
    int               nch;
    int               sent;
    int               count;
    int               blocks;
    bit               first_seg;

    edge_frames = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                    16'h0001, 16'h8001, 16'h7FFE, 16'h1234,
                    16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000,
                    16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF};
    sb       = new();
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // eight channels at the smallest step: the end-of-block sample releases
    // four interpolated frames and four tail frames, the largest burst
    apb_write(REG_CHANNELS, 8);
    apb_write(REG_STEP, MIN_STEP);
    for (int i = 0; i < 16; i++) send_sample(edge_frames[i], i == 15);
    wait_idle();

    // step below the minimum is clamped, zero channels act as one
    apb_write(REG_STEP, 1);
    apb_write(REG_CHANNELS, 0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0001, 1'b1);
    wait_idle();

    // channel count above the store size; block ends before a frame completes
    apb_write(REG_CHANNELS, 15);
    send_sample(16'h4000, 1'b0);
    send_sample(16'hC000, 1'b1);
    wait_idle();

    // huge step: one output frame, then the position is past the last frame
    apb_write(REG_STEP, 32'hFFFF_FFFF);
    apb_write(REG_CHANNELS, 1);
    send_sample(16'h2222, 1'b0);
    send_sample(16'hDDDD, 1'b0);
    send_sample(16'h0F0F, 1'b1);
    wait_idle();

    // channel count raised and then lowered in the middle of a frame
    apb_write(REG_STEP, POS_ONE / 2);
    apb_write(REG_CHANNELS, 2);
    send_sample(16'h1000, 1'b0);
    send_sample(16'hF000, 1'b0);
    send_sample(16'h7000, 1'b0);
    wait_idle();
    apb_write(REG_CHANNELS, 4);
    send_sample(16'h9000, 1'b0);
    wait_idle();
    apb_write(REG_CHANNELS, 3);
    send_sample(16'h3000, 1'b1);
    wait_idle();

    // random blocks under three idle patterns
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 74 : 0;
      recv_idle_pct = (mode == 0) ? 74 : (mode == 1) ? 38 : 0;
      sent          = 0;
      first_seg     = 1;
      while (sent < ITEMS_PER_MODE) begin
        pick_settings(st, cc);
        // long output hold-off with the input side running flat out
        if (mode == 2 && first_seg) st = MIN_STEP;
        apb_write(REG_STEP, st);
        apb_write(REG_CHANNELS, PDATA_W'(cc));
        nch = (cc == 0) ? 1 : (cc > MAX_CH) ? MAX_CH : cc;
        if (mode == 2 && first_seg) stall_req = 1;
        first_seg = 0;
        blocks = $urandom_range(1, 3);
        repeat (blocks) begin
          send_block(nch, count);
          sent += count;
        end
        wait_idle();
      end
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("linear_interp_resampler: match");
    end else begin
      $display("linear_interp_resampler: mismatch");
    end
    $finish;
  end
endmodule

/* linear_interp_resampler.f */
hw/rtl/lir_pkg.sv
hw/rtl/lir_cfg.sv
hw/rtl/lir_ctrl.sv
hw/rtl/lir_dpath.sv
hw/rtl/linear_interp_resampler.sv
bench/tb.sv
